[rtl/midi_byte_to_usb_packet_parser_core_assert.svh]
// assertion macros used by the checker file
`ifndef MIDI_BYTE_TO_USB_PACKET_PARSER_CORE_ASSERT_SVH
`define MIDI_BYTE_TO_USB_PACKET_PARSER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define MBUP_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mbup assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define MBUP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mbup assertion failed");

`endif

[rtl/mbup_pkg.sv]
package mbup_pkg;

   localparam logic [3:0] CODE_COMMON2 = 4'h2;
   localparam logic [3:0] CODE_COMMON3 = 4'h3;
   localparam logic [3:0] CODE_SYSEX   = 4'h4;
   localparam logic [3:0] CODE_END1    = 4'h5;
   localparam logic [3:0] CODE_END2    = 4'h6;
   localparam logic [3:0] CODE_END3    = 4'h7;
   localparam logic [3:0] CODE_SINGLE  = 4'hf;

   localparam logic [7:0] MIDI_SOX       = 8'hf0;
   localparam logic [7:0] MIDI_MTC       = 8'hf1;
   localparam logic [7:0] MIDI_SONG_POS  = 8'hf2;
   localparam logic [7:0] MIDI_SONG_SEL  = 8'hf3;
   localparam logic [7:0] MIDI_TUNE_REQ  = 8'hf6;
   localparam logic [7:0] MIDI_EOX       = 8'hf7;

   localparam logic [3:0] KIND_PROG_CHANGE = 4'hc;
   localparam logic [3:0] KIND_CHAN_PRESS  = 4'hd;

   localparam logic [1:0] POS_FIRST  = 2'd1;
   localparam logic [1:0] POS_SECOND = 2'd2;
   localparam logic [1:0] POS_THIRD  = 2'd3;

   typedef struct packed {
      logic       in_sysex;
      logic [1:0] bytes_needed;
      logic [1:0] byte_position;
      logic [3:0] code;
      logic [7:0] first;
      logic [7:0] second;
      logic [7:0] third;
   } state_type;

   typedef struct packed {
      logic       emit;
      logic [3:0] code;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
   } result_type;

endpackage

[rtl/mbup_step.sv]
module mbup_step
   import mbup_pkg::*;
(
   input  state_type  state,
   input  logic [7:0] rx_byte,
   output state_type  state_nxt,
   output result_type result
);

   always_comb begin
      state_nxt = state;
      result    = '0;
      if (state.in_sysex) begin
         if (rx_byte == MIDI_EOX) begin
            state_nxt.in_sysex = 1'b0;
            case (state.byte_position)
               POS_THIRD: begin
                  state_nxt.code  = CODE_END3;
                  state_nxt.third = rx_byte;
               end
               POS_SECOND: begin
                  state_nxt.code   = CODE_END2;
                  state_nxt.second = rx_byte;
               end
               default: begin
                  state_nxt.code  = CODE_END1;
                  state_nxt.first = rx_byte;
               end
            endcase
            state_nxt.byte_position = 2'd0;
            state_nxt.bytes_needed  = 2'd0;
            result.emit  = 1'b1;
            result.code  = state_nxt.code;
            result.byte0 = state_nxt.first;
            result.byte1 = state_nxt.second;
            result.byte2 = state_nxt.third;
         end else if (state.byte_position == POS_FIRST) begin
            state_nxt.first         = rx_byte;
            state_nxt.byte_position = POS_SECOND;
         end else if (state.byte_position == POS_SECOND) begin
            state_nxt.second        = rx_byte;
            state_nxt.byte_position = POS_THIRD;
         end else begin
            // full packet: flush with the code it was opened with
            state_nxt.third = rx_byte;
            result.emit     = 1'b1;
            result.code     = state.code;
            result.byte0    = state.first;
            result.byte1    = state.second;
            result.byte2    = rx_byte;
            state_nxt.code          = CODE_SYSEX;
            state_nxt.byte_position = POS_FIRST;
         end
      end else if (state.bytes_needed != 2'd0) begin
         case (state.byte_position)
            POS_FIRST: begin
               state_nxt.first         = rx_byte;
               state_nxt.byte_position = POS_SECOND;
            end
            POS_SECOND: begin
               state_nxt.second        = rx_byte;
               state_nxt.byte_position = POS_THIRD;
            end
            default: begin
               state_nxt.third = rx_byte;
            end
         endcase
         state_nxt.bytes_needed = state.bytes_needed - 2'd1;
         if (state_nxt.bytes_needed == 2'd0) begin
            result.emit  = 1'b1;
            result.code  = state_nxt.code;
            result.byte0 = state_nxt.first;
            result.byte1 = state_nxt.second;
            result.byte2 = state_nxt.third;
         end
      end else if (rx_byte inside {[8'hf8 : 8'hff]}) begin
         result.emit  = 1'b1;
         result.code  = CODE_SINGLE;
         result.byte0 = rx_byte;
      end else if (rx_byte inside {[8'h80 : 8'hef]}) begin
         state_nxt.code          = rx_byte[7:4];
         state_nxt.first         = rx_byte;
         state_nxt.byte_position = POS_SECOND;
         if (rx_byte[7:4] inside {KIND_PROG_CHANGE, KIND_CHAN_PRESS}) begin
            state_nxt.bytes_needed = 2'd1;
         end else begin
            state_nxt.bytes_needed = 2'd2;
         end
      end else begin
         case (rx_byte)
            MIDI_SOX: begin
               state_nxt.in_sysex      = 1'b1;
               state_nxt.bytes_needed  = 2'd2;
               state_nxt.byte_position = POS_SECOND;
               state_nxt.code          = CODE_SYSEX;
               state_nxt.first         = rx_byte;
            end
            MIDI_SONG_POS: begin
               state_nxt.code          = CODE_COMMON3;
               state_nxt.first         = rx_byte;
               state_nxt.bytes_needed  = 2'd2;
               state_nxt.byte_position = POS_SECOND;
            end
            MIDI_TUNE_REQ: begin
               state_nxt.code  = CODE_SINGLE;
               state_nxt.first = rx_byte;
               result.emit     = 1'b1;
               result.code     = CODE_SINGLE;
               result.byte0    = rx_byte;
               result.byte1    = state.second;
               result.byte2    = state.third;
            end
            MIDI_MTC, MIDI_SONG_SEL: begin
               state_nxt.code          = CODE_COMMON2;
               state_nxt.first         = rx_byte;
               state_nxt.bytes_needed  = 2'd1;
               state_nxt.byte_position = POS_SECOND;
            end
            default: begin
               state_nxt = state;
            end
         endcase
      end
   end

endmodule

[rtl/midi_byte_to_usb_packet_parser_core.sv]
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_rx_byte
// rsp       out        rsp_valid / rsp_ready  rsp_cable, rsp_code_index, rsp_byte0..2
// csr       in         csr_wr_en              csr_wr_data (cable number)
//
// one item per cycle sustained unless the result stalls; an accepted item
// passes the input register, then the parser step into the result register
// synchronous active-high reset clears parser state, cable number and valids
// a stalled result holds the result register; the input register still takes
// one item, then req_ready drops until the result is taken
module midi_byte_to_usb_packet_parser_core
   import mbup_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_cable,
   output logic [3:0] rsp_code_index,
   output logic [7:0] rsp_byte0,
   output logic [7:0] rsp_byte1,
   output logic [7:0] rsp_byte2,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result;
   logic [3:0] cable_ff;
   logic       rsp_valid_ff;
   logic [3:0] rsp_cable_ff;
   logic [3:0] rsp_code_ff;
   logic [7:0] rsp_byte0_ff;
   logic [7:0] rsp_byte1_ff;
   logic [7:0] rsp_byte2_ff;
   logic       advance;

   mbup_step u_step (
      .state     (state_ff),
      .rx_byte   (in_byte_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         cable_ff     <= 4'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (csr_wr_en) begin
            cable_ff <= csr_wr_data;
         end
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= result.emit;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && result.emit) begin
         rsp_cable_ff <= cable_ff;
         rsp_code_ff  <= result.code;
         rsp_byte0_ff <= result.byte0;
         rsp_byte1_ff <= result.byte1;
         rsp_byte2_ff <= result.byte2;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cable      = rsp_cable_ff;
   assign rsp_code_index = rsp_code_ff;
   assign rsp_byte0      = rsp_byte0_ff;
   assign rsp_byte1      = rsp_byte1_ff;
   assign rsp_byte2      = rsp_byte2_ff;

endmodule

[rtl/mbup_checker.sv]
`include "midi_byte_to_usb_packet_parser_core_assert.svh"

module mbup_checker
   import mbup_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_cable,
   input logic [3:0] rsp_code_index,
   input logic [7:0] rsp_byte0,
   input logic [7:0] rsp_byte1,
   input logic [7:0] rsp_byte2
);

   logic [31:0] rsp_item;
   logic        single_other;
   logic        realtime_shape;

   assign rsp_item       = {rsp_cable, rsp_code_index, rsp_byte0, rsp_byte1, rsp_byte2};
   assign single_other   = rsp_valid && rsp_code_index == CODE_SINGLE &&
                           rsp_byte0 != MIDI_TUNE_REQ;
   assign realtime_shape = rsp_byte0[7:3] == 5'h1f && rsp_byte1 == 8'h00 &&
                           rsp_byte2 == 8'h00;

   // stalled item holds
   `MBUP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))

   // single-byte packets other than tune request are real-time with zero data
   `MBUP_ASSERT(a_single_rt, single_other, realtime_shape)

   // sysex end codes carry the end byte in the matching slot
   `MBUP_ASSERT(a_end1, rsp_valid && rsp_code_index == CODE_END1, rsp_byte0 == MIDI_EOX)
   `MBUP_ASSERT(a_end2, rsp_valid && rsp_code_index == CODE_END2, rsp_byte1 == MIDI_EOX)
   `MBUP_ASSERT(a_end3, rsp_valid && rsp_code_index == CODE_END3, rsp_byte2 == MIDI_EOX)

endmodule

bind midi_byte_to_usb_packet_parser_core mbup_checker u_mbup_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cable      (rsp_cable),
   .rsp_code_index (rsp_code_index),
   .rsp_byte0      (rsp_byte0),
   .rsp_byte1      (rsp_byte1),
   .rsp_byte2      (rsp_byte2)
);
